// ===== rtl/crc8_frame_checker_unit_macros.svh =====
// Assertion macros for the CRC-8 frame checker.
// Used by the top level; needs clk and rst_n in scope.
`ifndef CRC8_FRAME_CHECKER_UNIT_MACROS_SVH
`define CRC8_FRAME_CHECKER_UNIT_MACROS_SVH

// Check that cond holds in any cycle where trig holds.
`define CRC8FC_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("crc8 frame checker assertion failed");

// Check that cond holds in the cycle after trig holds.
`define CRC8FC_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("crc8 frame checker assertion failed");

`endif

// ===== rtl/crc8fc_pkg.sv =====
// Shared types, constants and the CRC step for the CRC-8 frame checker.
// No dependencies.
`timescale 1ns / 1ps
package crc8fc_pkg;

    localparam int FRAME_BYTES_DEF = 8;
    localparam int NUM_W           = 16;
    localparam int DESC_CNT_W      = 6;
    localparam int QUEUE_DEPTH     = 2;
    localparam int Q_PTR_W         = $clog2(QUEUE_DEPTH);
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       ends_frame;
    } item_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             data_valid;
        logic             last_of_frame;
        logic             crc_error;
        logic [NUM_W-1:0] frame_number;
    } result_t;

    typedef struct packed {
        logic                  bank;
        logic [DESC_CNT_W-1:0] count;
        logic                  crc_error;
        logic [NUM_W-1:0]      frame_number;
    } desc_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;

    typedef struct packed {
        logic [1:0] busy;
        logic       wr_bank;
    } front_stat_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_DATA
    } back_state_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 8'd0)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc8fc_front.sv =====
// Front end: accepts frame words, runs the CRC, writes payload banks, queues frames.
// Depends on crc8fc_pkg.
`timescale 1ns / 1ps
module crc8fc_front
    import crc8fc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int CNT_W       = $clog2(FRAME_BYTES),
    parameter int ADDR_W      = CNT_W + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    input  logic              q_full,
    output logic              q_push,
    output desc_t             q_wdata,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    input  done_t             done,
    output front_stat_t       stat
);

    logic [7:0]       crc_reg, crc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic             accept;
    logic             is_end;

    assign item_ready = !busy_reg[bank_reg] && !q_full;
    assign accept     = item_valid && item_ready;
    assign is_end     = item.ends_frame || (cnt_reg == CNT_W'(FRAME_BYTES - 1));

    assign wr_en   = accept && !is_end;
    assign wr_addr = {bank_reg, cnt_reg};
    assign wr_data = item.frame_byte;

    assign q_push                = accept && is_end;
    assign q_wdata.bank          = bank_reg;
    assign q_wdata.count         = DESC_CNT_W'(cnt_reg);
    assign q_wdata.crc_error     = (item.frame_byte != crc_reg);
    assign q_wdata.frame_number  = num_reg;

    assign stat.busy    = busy_reg;
    assign stat.wr_bank = bank_reg;

    always_comb
    begin
        crc_next  = crc_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (done.valid)
            busy_next[done.bank] = 1'b0;
        if (wr_en)
        begin
            crc_next = crc8_update(crc_reg, item.frame_byte);
            cnt_next = cnt_reg + 1'b1;
        end
        if (q_push)
        begin
            crc_next            = 8'd0;
            cnt_next            = '0;
            num_next            = num_reg + 1'b1;
            bank_next           = !bank_reg;
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= 8'd0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            bank_reg <= 1'b0;
            busy_reg <= 2'b00;
        end
        else
        begin
            crc_reg  <= crc_next;
            cnt_reg  <= cnt_next;
            num_reg  <= num_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== rtl/crc8fc_queue.sv =====
// Two-entry frame descriptor queue between front and back.
// Depends on crc8fc_pkg.
`timescale 1ns / 1ps
module crc8fc_queue
    import crc8fc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t wdata,
    input  logic  pop,
    output desc_t rdata,
    output logic  empty,
    output logic  full
);

    desc_t                entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W:0]     count_reg, count_next;

    assign rdata = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == (Q_PTR_W + 1)'(QUEUE_DEPTH));

    always_comb
    begin
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== rtl/crc8fc_back.sv =====
// Back end: holds the payload banks, drains queued frames into the result register.
// Depends on crc8fc_pkg.
`timescale 1ns / 1ps
module crc8fc_back
    import crc8fc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int CNT_W       = $clog2(FRAME_BYTES),
    parameter int ADDR_W      = CNT_W + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              q_empty,
    input  desc_t             q_rdata,
    output logic              q_pop,
    output done_t             done,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    logic [7:0]       mem [2**ADDR_W];
    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, cnt_reg;
    logic             bank_reg;
    logic [NUM_W-1:0] num_reg, pend_num_reg;
    logic             pend_reg, pend_next, pend_last_reg;
    logic [7:0]       rdata_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg;
    logic             out_free, load, issue, last_issue, single, single_load;

    assign out_free = !out_valid_reg || result_ready;
    assign load     = pend_reg && out_free;
    assign single   = q_rdata.crc_error || (q_rdata.count == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (q_pop && !single)
                    state_next = BACK_DATA;
            end
            BACK_DATA:
            begin
                if (last_issue)
                    state_next = BACK_IDLE;
            end
            default: state_next = BACK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop      = 1'b0;
        issue      = 1'b0;
        last_issue = 1'b0;
        unique case (state_reg)
            BACK_IDLE:
            begin
                q_pop = !q_empty && (!single || (!pend_reg && out_free));
            end
            BACK_DATA:
            begin
                issue      = !pend_reg || load;
                last_issue = issue && (idx_reg == cnt_reg - 1'b1);
            end
            default: ;
        endcase
        single_load = q_pop && single;
        done.valid  = single_load || last_issue;
        done.bank   = single_load ? q_rdata.bank : bank_reg;
    end

    assign pend_next      = issue ? 1'b1 : (load ? 1'b0 : pend_reg);
    assign out_valid_next = (single_load || load) ? 1'b1
                          : (result_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (issue)
            rdata_reg <= mem[{bank_reg, idx_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bank_reg <= q_rdata.bank;
            cnt_reg  <= q_rdata.count[CNT_W-1:0];
            num_reg  <= q_rdata.frame_number;
            idx_reg  <= '0;
        end
        else if (issue)
            idx_reg <= idx_reg + 1'b1;
        if (issue)
        begin
            pend_last_reg <= last_issue;
            pend_num_reg  <= num_reg;
        end
        if (single_load)
        begin
            out_reg.data_byte     <= 8'd0;
            out_reg.data_valid    <= 1'b0;
            out_reg.last_of_frame <= 1'b1;
            out_reg.crc_error     <= q_rdata.crc_error;
            out_reg.frame_number  <= q_rdata.frame_number;
        end
        else if (load)
        begin
            out_reg.data_byte     <= rdata_reg;
            out_reg.data_valid    <= 1'b1;
            out_reg.last_of_frame <= pend_last_reg;
            out_reg.crc_error     <= 1'b0;
            out_reg.frame_number  <= pend_num_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== rtl/crc8_frame_checker_unit.sv =====
// Top level of the CRC-8 frame checker: front end, descriptor queue, back end.
// Depends on crc8fc_pkg, crc8fc_front, crc8fc_queue, crc8fc_back and the macro header.
//
// Channel   Handshake                    Word
// item      item_valid / item_ready      item_t   (frame_byte, ends_frame)
// result    result_valid / result_ready  result_t (data_byte .. frame_number)
//
// Input takes one word per cycle while a payload bank is free and the queue has room.
// Each passing frame drains at one result per cycle while result_ready allows, paced by the
// single read port of the payload memory; failed or empty frames give one result.
// Two payload banks: input stalls only when both hold frames not yet drained.
// Reset clears counters, CRC, bank flags, queue and result valid; no clearing pass.
`timescale 1ns / 1ps
`include "crc8_frame_checker_unit_macros.svh"
module crc8_frame_checker_unit
    import crc8fc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int CNT_W  = $clog2(FRAME_BYTES);
    localparam int ADDR_W = CNT_W + 1;

    logic              q_push, q_pop, q_empty, q_full;
    desc_t             q_wdata, q_rdata;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    done_t             done;
    front_stat_t       stat;

    crc8fc_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .CNT_W       (CNT_W),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .done       (done),
        .stat       (stat)
    );

    crc8fc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    crc8fc_back #(
        .FRAME_BYTES (FRAME_BYTES),
        .CNT_W       (CNT_W),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .q_empty      (q_empty),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .done         (done),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    `CRC8FC_ASSERT_NOW(a_push_has_room, q_push, !q_full)
    `CRC8FC_ASSERT_NOW(a_pop_has_entry, q_pop, !q_empty)
    `CRC8FC_ASSERT_NOW(a_done_bank_busy, done.valid, stat.busy[done.bank])
    `CRC8FC_ASSERT_NEXT(a_push_marks_busy, q_push, stat.busy[$past(stat.wr_bank)])

endmodule

// ===== tb/sv/crc8_frame_checker_unit_checker.sv =====
// Scoreboard for the CRC-8 frame checker: watches both channels, predicts results.
// Depends on crc8fc_pkg for the word types; reports a failure count and backlog.
`timescale 1ns / 1ps
module crc8_frame_checker_unit_checker
    import crc8fc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_ready,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result,
    output int      fail_count,
    output int      backlog
);

    logic [7:0]       crc_acc;
    logic [7:0]       held_bytes [FRAME_BYTES-1];
    int               held;
    logic [NUM_W-1:0] frame_idx;
    result_t          due_results [$];

    // Bit-serial CRC-8, MSB first, polynomial x^8 + x^2 + x + 1.
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
        end
        return c;
    endfunction

    task automatic take_frame_byte(input item_t w);
        result_t r;
        if (!w.ends_frame && held < FRAME_BYTES - 1)
        begin
            held_bytes[held] = w.frame_byte;
            crc_acc = crc_step(crc_acc, w.frame_byte);
            held++;
        end
        else
        begin
            r = '0;
            r.frame_number = frame_idx;
            if (w.frame_byte != crc_acc || held == 0)
            begin
                r.last_of_frame = 1'b1;
                r.crc_error = (w.frame_byte != crc_acc);
                due_results.push_back(r);
            end
            else
            begin
                for (int i = 0; i < held; i++)
                begin
                    r.data_byte = held_bytes[i];
                    r.data_valid = 1'b1;
                    r.last_of_frame = (i == held - 1);
                    due_results.push_back(r);
                end
            end
            crc_acc = 8'h00;
            held = 0;
            frame_idx = frame_idx + 1'b1;
        end
    endtask

    task automatic match_result(input result_t got);
        result_t want;
        if (due_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: unexpected result word: data=%h valid=%b last=%b err=%b num=%0d",
                         $realtime, got.data_byte, got.data_valid, got.last_of_frame,
                         got.crc_error, got.frame_number);
        end
        else
        begin
            want = due_results.pop_front();
            if (got.data_byte !== want.data_byte || got.data_valid !== want.data_valid ||
                got.last_of_frame !== want.last_of_frame ||
                got.crc_error !== want.crc_error || got.frame_number !== want.frame_number)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $write("%0t: mismatch: expected data=%h valid=%b last=%b err=%b num=%0d,",
                           $realtime, want.data_byte, want.data_valid, want.last_of_frame,
                           want.crc_error, want.frame_number);
                    $display(" got data=%h valid=%b last=%b err=%b num=%0d",
                             got.data_byte, got.data_valid, got.last_of_frame,
                             got.crc_error, got.frame_number);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_acc = 8'h00;
            held = 0;
            frame_idx = '0;
            due_results.delete();
            fail_count = 0;
            backlog = 0;
        end
        else
        begin
            if (item_valid && item_ready)
                take_frame_byte(item);
            if (result_valid && result_ready)
                match_result(result);
            backlog = due_results.size();
        end
    end

endmodule

// ===== tb/sv/crc8_frame_checker_unit_tb.sv =====
// Testbench top for the CRC-8 frame checker: clock, reset, frame stimulus, verdict.
// Depends on crc8fc_pkg, crc8_frame_checker_unit and crc8_frame_checker_unit_checker.
`timescale 1ns / 1ps
module crc8_frame_checker_unit_tb;
    import crc8fc_pkg::*;

    localparam int FRAME_BYTES = FRAME_BYTES_DEF;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;
    int      fail_count;
    int      backlog;
    logic    gaps_on;
    int      items_sent;

    crc8_frame_checker_unit #(.FRAME_BYTES(FRAME_BYTES)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    crc8_frame_checker_unit_checker #(.FRAME_BYTES(FRAME_BYTES)) chk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .backlog      (backlog)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] frame_crc_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8)
            c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
        return c;
    endfunction

    task automatic push_word(input logic [7:0] b, input logic e);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= '{frame_byte: b, ends_frame: e};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] payload [FRAME_BYTES-1], input int n,
                              input bit bad, input bit mark);
        logic [7:0] crc;
        logic [7:0] flip;
        crc = 8'h00;
        for (int i = 0; i < n; i++)
        begin
            crc = frame_crc_next(crc, payload[i]);
            push_word(payload[i], 1'b0);
        end
        flip = 8'($urandom_range(1, 255));
        push_word(bad ? (crc ^ flip) : crc, (n < FRAME_BYTES - 1) ? 1'b1 : mark);
        items_sent += n + 1;
    endtask

    task automatic send_random_frame();
        logic [7:0] payload [FRAME_BYTES-1];
        int n;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            payload[i] = 8'($urandom);
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, FRAME_BYTES - 2) : FRAME_BYTES - 1;
        send_frame(payload, n, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: insert random stalls between words while gaps are on.
    initial
    begin
        int stall;
        result_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [7:0] pl [FRAME_BYTES-1];
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        gaps_on = 1'b1;
        items_sent = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        pl = '{default: 8'h00};
        send_frame(pl, FRAME_BYTES - 1, 1'b0, 1'b0);
        pl = '{default: 8'hFF};
        send_frame(pl, FRAME_BYTES - 1, 1'b0, 1'b1);
        send_frame(pl, 0, 1'b0, 1'b1);
        pl[0] = 8'h00;
        send_frame(pl, 0, 1'b1, 1'b1);
        pl[0] = 8'h80;
        send_frame(pl, 1, 1'b0, 1'b1);
        pl[0] = 8'h5A;
        pl[1] = 8'hA5;
        send_frame(pl, 2, 1'b1, 1'b1);

        while (items_sent < 100)
            send_random_frame();
        item_valid <= 1'b0;

        while (backlog != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && backlog == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
